/* hw/rtl/lcar_pkg.sv */
// shared types, widths and codes for the load-cell converter reader
`timescale 1ns / 1ps

package lcar_pkg;

	localparam int DATA_BITS  = 24;
	localparam int DROP_BITS  = 6;
	localparam int CHANNELS   = 3;
	localparam int VAL_W      = 18;
	localparam int CNT_W      = 8;
	localparam int SUM_W      = VAL_W + CNT_W;
	localparam int BCNT_W     = 5;
	localparam int GAIN_W     = 2;
	localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_MEASURE = 2'd1,
		KIND_TARE    = 2'd2,
		KIND_LOAD    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_GAIN  = 2'd0,
		REG_AVG   = 2'd1,
		REG_PDOWN = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_WAIT      = 3'd1,
		PH_BIT_HIGH  = 3'd2,
		PH_BIT_LOW   = 3'd3,
		PH_GAIN_HIGH = 3'd4,
		PH_GAIN_LOW  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		CTL_IDLE = 2'd0,
		CTL_DIV  = 2'd1,
		CTL_FIN  = 2'd2
	} ctl_t;

	// divider request and status
	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

	// net value is divided by 4, 1 or 2 for the three gain settings
	function automatic logic [1:0] amp_shift(input logic [GAIN_W-1:0] g);
		logic [1:0] s;
		case (g)
			2'd0:    s = 2'd2;
			2'd1:    s = 2'd0;
			default: s = 2'd1;
		endcase
		return s;
	endfunction

endpackage

/* hw/rtl/lcar_div.sv */
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps

module lcar_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lcar_pkg::div_req_t req,
	output lcar_pkg::div_rsp_t rsp
);
	import lcar_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     den_q;
	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W:0]       trial;
	logic [CNT_W:0]       diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* hw/rtl/load_cell_adc_reader.sv */
// load-cell converter reader: serial clock sequencer, averaging and tare
//
//  channel | handshake         | payload
//  s_      | s_tvalid/s_tready | tuser kind, tdata data_line/target_channel/offset_value
//  m_      | m_tvalid/m_tready | tdata clock_out/busy_res/result_valid/result_value,
//          |                   | tuser result_is_tare
//  cfg_    | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// an ordinary tick goes from accept straight into the output register
// the tick that ends a measure or tare starts the serial divider, which produces
// one quotient bit per cycle; offset and scaling are applied as the result is loaded
// s_tready is low while the divider runs and while an item waits on a stalled m_tready
// reset clears the sequence, the offsets and the registers to their defaults
`timescale 1ns / 1ps

module load_cell_adc_reader (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [0] data_line, [2:1] target_channel, [20:3] offset_value
	input  logic [lcar_pkg::IN_DATA_W-1:0]  s_tdata,
	// [1:0] kind
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] clock_out, [1] busy_res, [2] result_valid, [20:3] result_value
	output logic [lcar_pkg::OUT_DATA_W-1:0] m_tdata,
	// [0] result_is_tare
	output logic                            m_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [7:0]                      cfg_data
);
	import lcar_pkg::*;

	// configuration
	logic [GAIN_W-1:0] gain_q;
	logic [CNT_W-1:0]  avg_cnt_q;
	logic              pdown_q;

	// sequence state
	phase_t               phase_q, phase_n;
	logic [BCNT_W-1:0]    bcnt_q, bcnt_n;
	logic [DATA_BITS-1:0] shift_q, shift_n;
	logic [SUM_W-1:0]     sum_q, sum_n;
	logic [CNT_W-1:0]     conv_q, conv_n;
	logic                 tare_q, tare_n;
	logic [VAL_W-1:0]     offs_q [CHANNELS];

	// finish bookkeeping
	ctl_t              ctl_q, ctl_n;
	logic [GAIN_W-1:0] fin_gain_q;
	logic              fin_tare_q;

	// output register
	logic              m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic              m_tare_q;

	logic              in_acc;
	logic              out_free;
	logic              fin;
	logic              clk_lvl;
	logic              busy_lvl;
	logic [CNT_W-1:0]  n_eff;
	logic [CNT_W-1:0]  conv_inc;
	logic [VAL_W-1:0]  conv_val;
	logic [VAL_W-1:0]  avg;
	logic [VAL_W-1:0]  off_sel;
	logic [VAL_W-1:0]  net;
	logic [VAL_W-1:0]  fin_value;
	logic              fin_load;
	kind_t             kind;
	logic              data_line;
	logic [1:0]        tchan;
	logic [VAL_W-1:0]  offv;
	div_req_t          dreq;
	div_rsp_t          drsp;

	assign kind      = kind_t'(s_tuser);
	assign data_line = s_tdata[0];
	assign tchan     = s_tdata[2:1];
	assign offv      = s_tdata[VAL_W+2:3];

	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = (ctl_q == CTL_IDLE) && out_free;
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign n_eff    = (avg_cnt_q == '0) ? CNT_W'(1) : avg_cnt_q;
	assign conv_inc = conv_q + CNT_W'(1);
	assign conv_val = VAL_W'(shift_q >> DROP_BITS);

	// one tick of the converter sequence
	always_comb begin
		phase_n = phase_q;
		bcnt_n  = bcnt_q;
		shift_n = shift_q;
		sum_n   = sum_q;
		conv_n  = conv_q;
		tare_n  = tare_q;
		fin     = 1'b0;
		if (pdown_q) begin
			phase_n = PH_IDLE;
			bcnt_n  = '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (kind == KIND_MEASURE || kind == KIND_TARE) begin
						tare_n  = (kind == KIND_TARE);
						sum_n   = '0;
						conv_n  = '0;
						bcnt_n  = '0;
						shift_n = '0;
						phase_n = PH_WAIT;
					end
				end
				PH_WAIT: begin
					if (!data_line) begin
						bcnt_n  = '0;
						shift_n = '0;
						phase_n = PH_BIT_HIGH;
					end
				end
				PH_BIT_HIGH: phase_n = PH_BIT_LOW;
				PH_BIT_LOW: begin
					shift_n = {shift_q[DATA_BITS-2:0], data_line};
					if (bcnt_q == BCNT_W'(DATA_BITS - 1)) begin
						bcnt_n  = '0;
						phase_n = PH_GAIN_HIGH;
					end else begin
						bcnt_n  = bcnt_q + BCNT_W'(1);
						phase_n = PH_BIT_HIGH;
					end
				end
				PH_GAIN_HIGH: phase_n = PH_GAIN_LOW;
				PH_GAIN_LOW: begin
					if (bcnt_q < BCNT_W'(gain_q)) begin
						bcnt_n  = bcnt_q + BCNT_W'(1);
						phase_n = PH_GAIN_HIGH;
					end else begin
						bcnt_n = '0;
						sum_n  = sum_q + SUM_W'(conv_val);
						conv_n = conv_inc;
						if (conv_inc < n_eff) begin
							phase_n = PH_WAIT;
						end else begin
							fin     = 1'b1;
							tare_n  = 1'b0;
							phase_n = PH_IDLE;
						end
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end
		clk_lvl  = pdown_q || phase_n == PH_BIT_HIGH || phase_n == PH_GAIN_HIGH;
		busy_lvl = phase_n != PH_IDLE;
	end

	assign dreq.start    = in_acc && fin;
	assign dreq.dividend = sum_n;
	assign dreq.divisor  = n_eff;

	lcar_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// offset and scaling after the average is known
	assign avg       = drsp.quotient[VAL_W-1:0];
	assign off_sel   = offs_q[fin_gain_q];
	assign net       = (avg > off_sel) ? ((avg - off_sel) >> amp_shift(fin_gain_q)) : '0;
	assign fin_value = fin_tare_q ? avg : net;
	assign fin_load  = (ctl_q == CTL_FIN) && out_free;

	always_comb begin
		ctl_n = ctl_q;
		case (ctl_q)
			CTL_IDLE: if (dreq.start) ctl_n = CTL_DIV;
			CTL_DIV:  if (drsp.done) ctl_n = CTL_FIN;
			CTL_FIN:  if (out_free) ctl_n = CTL_IDLE;
			default:  ctl_n = CTL_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= CTL_IDLE;
		end else begin
			ctl_q <= ctl_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= '0;
			avg_cnt_q <= CNT_W'(1);
			pdown_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_GAIN:  if (cfg_data[1:0] < 2'(CHANNELS)) gain_q <= cfg_data[1:0];
				REG_AVG:   avg_cnt_q <= cfg_data;
				REG_PDOWN: pdown_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bcnt_q  <= '0;
			shift_q <= '0;
			sum_q   <= '0;
			conv_q  <= '0;
			tare_q  <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) offs_q[i] <= '0;
		end else begin
			if (in_acc) begin
				phase_q <= phase_n;
				bcnt_q  <= bcnt_n;
				shift_q <= shift_n;
				sum_q   <= sum_n;
				conv_q  <= conv_n;
				tare_q  <= tare_n;
				if (!pdown_q && kind == KIND_LOAD && tchan < 2'(CHANNELS))
					offs_q[tchan] <= offv;
			end
			if (fin_load && fin_tare_q)
				offs_q[fin_gain_q] <= avg;
		end
	end

	always_ff @(posedge clk) begin
		if (dreq.start) begin
			fin_gain_q <= gain_q;
			fin_tare_q <= tare_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (in_acc && !fin) begin
			m_valid_q <= 1'b1;
		end else if (fin_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// a finishing tick always leaves the clock low and the sequence idle
	always_ff @(posedge clk) begin
		if (in_acc && !fin) begin
			m_data_q <= OUT_DATA_W'({busy_lvl, clk_lvl});
			m_tare_q <= 1'b0;
		end else if (fin_load) begin
			m_data_q <= OUT_DATA_W'({fin_value, 1'b1, 1'b0, 1'b0});
			m_tare_q <= fin_tare_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_tare_q;

endmodule

/* test/tb_load_cell_adc_reader.sv */
// self-checking testbench for the load-cell converter reader
`timescale 1ns / 1ps

module tb_load_cell_adc_reader;
	import lcar_pkg::*;

	localparam int unsigned NET_DIV [CHANNELS] = '{4, 1, 2};
	// index past the last register, writes to it change nothing
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic             clock_out;
		logic             busy;
		logic             valid;
		logic             is_tare;
		logic [VAL_W-1:0] value;
	} reading_t;

	class load_cell_tracker;
		phase_t           phase;
		logic [4:0]       bit_cnt;
		logic [23:0]      shift_reg;
		logic [SUM_W-1:0] acc_sum;
		logic [7:0]       conv_done;
		bit               tare_pend;
		logic [VAL_W-1:0] offsets [CHANNELS];
		logic [1:0]       gain;
		logic [7:0]       avg_cnt;
		bit               pdown;
		reading_t         pending_readings [$];
		int               errors;

		function new();
			phase = PH_IDLE;
			bit_cnt = '0;
			shift_reg = '0;
			acc_sum = '0;
			conv_done = '0;
			tare_pend = 1'b0;
			foreach (offsets[i]) offsets[i] = '0;
			gain = '0;
			avg_cnt = 8'd1;
			pdown = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				REG_GAIN: begin
					if (val[1:0] < CHANNELS) gain = val[1:0];
				end
				REG_AVG:   avg_cnt = val;
				REG_PDOWN: pdown = val[0];
				default: ;
			endcase
		endfunction

		function void accept_tick(kind_t kind, bit data, logic [1:0] chan,
				logic [VAL_W-1:0] offv);
			reading_t         r;
			int unsigned      g;
			int unsigned      n;
			logic [VAL_W-1:0] avg;
			logic [VAL_W-1:0] off;
			r = '0;
			g = (gain < CHANNELS) ? gain : CHANNELS - 1;
			n = (avg_cnt == 0) ? 1 : avg_cnt;
			if (pdown) begin
				phase = PH_IDLE;
				bit_cnt = '0;
			end else begin
				// a load writes even while a sequence runs
				if (kind == KIND_LOAD && chan < CHANNELS) offsets[chan] = offv;
				case (phase)
					PH_IDLE: begin
						if (kind == KIND_MEASURE || kind == KIND_TARE) begin
							tare_pend = (kind == KIND_TARE);
							acc_sum = '0;
							conv_done = '0;
							bit_cnt = '0;
							shift_reg = '0;
							phase = PH_WAIT;
						end
					end
					PH_WAIT: begin
						if (!data) begin
							bit_cnt = '0;
							shift_reg = '0;
							phase = PH_BIT_HIGH;
						end
					end
					PH_BIT_HIGH: phase = PH_BIT_LOW;
					PH_BIT_LOW: begin
						shift_reg = {shift_reg[22:0], data};
						if (bit_cnt + 1 >= DATA_BITS) begin
							bit_cnt = '0;
							phase = PH_GAIN_HIGH;
						end else begin
							bit_cnt = bit_cnt + 1'b1;
							phase = PH_BIT_HIGH;
						end
					end
					PH_GAIN_HIGH: phase = PH_GAIN_LOW;
					PH_GAIN_LOW: begin
						if (bit_cnt + 1 < g + 1) begin
							bit_cnt = bit_cnt + 1'b1;
							phase = PH_GAIN_HIGH;
						end else begin
							bit_cnt = '0;
							acc_sum = acc_sum + shift_reg[DATA_BITS-1:DROP_BITS];
							conv_done = conv_done + 1'b1;
							if (conv_done < n) begin
								phase = PH_WAIT;
							end else begin
								avg = VAL_W'(acc_sum / n);
								r.valid = 1'b1;
								if (tare_pend) begin
									offsets[g] = avg;
									r.is_tare = 1'b1;
									r.value = avg;
								end else begin
									off = offsets[g];
									r.value = (avg > off) ?
										VAL_W'((avg - off) / NET_DIV[g]) : '0;
								end
								phase = PH_IDLE;
								tare_pend = 1'b0;
							end
						end
					end
					default: phase = PH_IDLE;
				endcase
			end
			r.clock_out = pdown || phase == PH_BIT_HIGH || phase == PH_GAIN_HIGH;
			r.busy = (phase != PH_IDLE);
			pending_readings.push_back(r);
		endfunction

		function void compare_field(string name, logic [VAL_W-1:0] want,
				logic [VAL_W-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			end
		endfunction

		function void check_reading(reading_t got);
			reading_t want;
			if (pending_readings.size() == 0) begin
				errors++;
				$display("%0t: item expected none got %h", $time, got);
				return;
			end
			want = pending_readings.pop_front();
			compare_field("clock_out", want.clock_out, got.clock_out);
			compare_field("busy_res", want.busy, got.busy);
			compare_field("result_valid", want.valid, got.valid);
			compare_field("result_is_tare", want.is_tare, got.is_tare);
			compare_field("result_value", want.value, got.value);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [1:0]            cfg_index = '0;
	logic [7:0]            cfg_data = '0;

	load_cell_tracker sb;
	int               send_idle_pct = 0;
	int               recv_stall_pct = 0;
	logic [23:0]      conv_word = '0;

	load_cell_adc_reader DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_reading({m_tdata[0], m_tdata[1], m_tdata[2], m_tuser, m_tdata[20:3]});
		end
	end

	task set_idling(int m);
		case (m % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
			default: begin send_idle_pct = 13; recv_stall_pct = 13; end
		endcase
	endtask

	task drive_tick(kind_t kind, bit data, logic [1:0] chan, logic [VAL_W-1:0] offv);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = {3'b000, offv, chan, data};
		do @(posedge clk); while (!s_tready);
		sb.accept_tick(kind, data, chan, offv);
		@(negedge clk);
	endtask

	// registers change only with nothing in flight
	task program_reg(logic [1:0] idx, logic [7:0] val);
		s_tvalid = 1'b0;
		while (sb.pending_readings.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// mostly well-formed conversions, with some stray commands mixed in
	task random_item();
		kind_t            kind;
		bit               data;
		logic [1:0]       chan;
		logic [VAL_W-1:0] offv;
		int               r;
		int               w;
		chan = 2'($urandom_range(0, 3));
		offv = $urandom_range(0, 1) ? VAL_W'($urandom_range(0, 4095)) :
			VAL_W'($urandom_range(0, 262143));
		data = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (sb.pdown) begin
			kind = kind_t'($urandom_range(0, 3));
		end else if (sb.phase == PH_IDLE) begin
			kind = (r < 45) ? KIND_MEASURE : (r < 65) ? KIND_TARE :
				(r < 80) ? KIND_LOAD : KIND_TICK;
		end else begin
			kind = (r < 3) ? kind_t'($urandom_range(0, 3)) : (r < 6) ? KIND_LOAD : KIND_TICK;
			if (sb.phase == PH_WAIT) begin
				data = ($urandom_range(0, 2) == 0);
				if (!data) begin
					w = $urandom_range(0, 7);
					conv_word = (w == 0) ? 24'hFFFFFF : (w == 1) ? 24'h000000 :
						(w == 2) ? (24'hFC0000 | 24'($urandom)) : 24'($urandom);
				end
			end else if (sb.phase == PH_BIT_LOW) begin
				data = conv_word[DATA_BITS - 1 - sb.bit_cnt];
			end
		end
		drive_tick(kind, data, chan, offv);
	endtask

	initial begin
		int ph;
		int len;
		int random_items;
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes, every kind, ignored commands, power down
		set_idling(0);
		program_reg(REG_GAIN, 8'h00);
		program_reg(REG_AVG, 8'h01);
		program_reg(REG_PDOWN, 8'h00);
		program_reg(REG_UNUSED, 8'($urandom));
		drive_tick(KIND_TICK, 1'b0, 2'd0, 18'h00000);
		drive_tick(KIND_TICK, 1'b1, 2'd3, 18'h3FFFF);
		drive_tick(KIND_LOAD, 1'b1, 2'd0, 18'h3FFFF);
		drive_tick(KIND_LOAD, 1'b0, 2'd1, 18'h00000);
		drive_tick(KIND_LOAD, 1'b1, 2'd2, 18'h2AAAA);
		// channel 3 does not exist
		drive_tick(KIND_LOAD, 1'b0, 2'd3, 18'h15555);
		drive_tick(KIND_MEASURE, 1'b0, 2'd1, 18'h3FFFF);
		drive_tick(KIND_TARE, 1'b1, 2'd2, 18'h00000);
		drive_tick(KIND_MEASURE, 1'b1, 2'd0, 18'h00000);
		drive_tick(KIND_LOAD, 1'b1, 2'd1, 18'h15555);
		drive_tick(KIND_TICK, 1'b0, 2'd0, 18'h00000);
		drive_tick(KIND_TICK, 1'b1, 2'd0, 18'h00000);
		drive_tick(KIND_TICK, 1'b1, 2'd0, 18'h00000);
		drive_tick(KIND_TICK, 1'b0, 2'd0, 18'h00000);
		// power down aborts the running sequence and ignores every measure, tare and load
		program_reg(REG_PDOWN, 8'hFF);
		drive_tick(KIND_MEASURE, 1'b0, 2'd0, 18'h00000);
		drive_tick(KIND_TARE, 1'b0, 2'd0, 18'h00000);
		drive_tick(KIND_LOAD, 1'b1, 2'd0, 18'h00005);
		drive_tick(KIND_TICK, 1'b1, 2'd2, 18'h3FFFF);
		program_reg(REG_PDOWN, 8'h00);
		program_reg(REG_GAIN, 8'hFF);
		program_reg(REG_GAIN, 8'h02);
		drive_tick(KIND_LOAD, 1'b0, 2'd0, 18'h00000);
		drive_tick(KIND_LOAD, 1'b0, 2'd1, 18'h00000);
		drive_tick(KIND_LOAD, 1'b0, 2'd2, 18'h00000);

		// random phases, registers changed between them, sometimes mid-sequence
		random_items = 0;
		ph = 0;
		while (random_items < 900) begin
			set_idling(ph);
			if ($urandom_range(0, 1))
				program_reg(REG_GAIN, {6'($urandom), 2'($urandom_range(0, 3))});
			if ($urandom_range(0, 1))
				program_reg(REG_AVG, ($urandom_range(0, 9) < 9) ?
					8'($urandom_range(0, 3)) : 8'($urandom_range(4, 8)));
			if ($urandom_range(0, 1))
				program_reg(REG_PDOWN, {7'($urandom), ($urandom_range(0, 7) == 0)});
			len = sb.pdown ? $urandom_range(5, 20) : $urandom_range(40, 250);
			repeat (len) begin
				if (!sb.pdown) random_items++;
				random_item();
			end
			ph++;
		end

		// largest count, then lowered below the conversions already done
		while (sb.phase != PH_IDLE) random_item();
		set_idling(0);
		program_reg(REG_PDOWN, 8'h00);
		program_reg(REG_GAIN, 8'($urandom_range(0, 2)));
		program_reg(REG_AVG, 8'hFF);
		drive_tick(KIND_MEASURE, 1'b1, 2'($urandom), 18'($urandom));
		do random_item(); while (sb.conv_done < 8'd2);
		program_reg(REG_AVG, 8'h01);
		do random_item(); while (sb.phase != PH_IDLE);

		s_tvalid = 1'b0;
		while (sb.pending_readings.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb_load_cell_adc_reader: done, clean");
		end else begin
			$display("tb_load_cell_adc_reader: done, errors");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("tb_load_cell_adc_reader: done, errors");
		$finish;
	end

endmodule
